>>> rtl/crc16_frame_append_check_top_assert.svh
// ----------------------------------------------------------------------------
// crc16 framer assertion macros
// shared property forms for the framer's concurrent checks
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_APPEND_CHECK_TOP_ASSERT_SVH
`define CRC16_FRAME_APPEND_CHECK_TOP_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define CRCFAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define CRCFAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/crcfac_pkg.sv
// ----------------------------------------------------------------------------
// crcfac_pkg
// types, constants and the crc byte fold shared by the framer modules
// ----------------------------------------------------------------------------
package crcfac_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOPBIT = 16'h8000;

  // front to back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // configuration register map
  localparam int          CFG_AW             = 3;
  localparam logic        CFG_IDX_CHECK_MODE = 1'b0;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    logic        check;
    logic [15:0] crc;
  } crcfac_entry_t;

  typedef enum logic [2:0] {
    PH_DATA = 3'b001,
    PH_HI   = 3'b010,
    PH_LO   = 3'b100
  } crcfac_phase_t;

  // one byte into the crc, msb first
  function automatic logic [15:0] crcfac_fold(input logic [15:0] crc,
                                              input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/crc16_frame_append_check_top.sv
// ----------------------------------------------------------------------------
// crc16_frame_append_check_top
// crc-16 (0x1021, init 0, msb first) frame framer and checker
// ----------------------------------------------------------------------------
// input queue side: push with in_data_byte / in_frame_end, held off by full.
// result queue side: a word waits on the out_ ports while empty is low and
// leaves when pop is high.
// append mode (check_mode 0): every byte passes through; the last byte of a
// frame is followed by the crc high and low bytes, the low one with
// out_last set. check mode: one word per byte, crc_good on the last byte
// tells whether the remainder is zero.
// an accepted word goes through the word queue into the output register
// once the result side is free. throughput: one byte per cycle while pop
// keeps the result side free; the last byte of an append frame stays at
// the queue head for its data, crc high and crc low words, and a four-entry
// word queue absorbs short bursts. reset clears the crc, the queues and
// check_mode; the crc also clears after every frame. when pop stays low the
// word queue fills and full rises. check_mode sits at apb address 0, to be
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "crc16_frame_append_check_top_assert.svh"

module crc16_frame_append_check_top import crcfac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_frame_end,
  // result channel
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_out_byte,
  output logic              out_is_crc_byte,
  output logic              out_out_last,
  output logic              out_crc_good,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic          check_mode_r, check_mode_nxt;
  logic          cfg_wr;
  logic          q_full, q_push, q_pop, q_empty;
  crcfac_entry_t q_entry, q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    check_mode_nxt = check_mode_r;
    if (cfg_wr && paddr[2] == CFG_IDX_CHECK_MODE) begin
      check_mode_nxt = pwdata[0];
    end
    prdata = 32'h0000_0000;
    if (paddr[2] == CFG_IDX_CHECK_MODE) begin
      prdata = {31'h0000_0000, check_mode_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= 1'b0;
    end else begin
      check_mode_r <= check_mode_nxt;
    end
  end

  crcfac_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .data_byte  (in_data_byte),
    .frame_end  (in_frame_end),
    .check_mode (check_mode_r),
    .q_full     (q_full),
    .full       (full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  crcfac_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  crcfac_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_out_byte),
    .is_crc_byte (out_is_crc_byte),
    .out_last    (out_out_last),
    .crc_good    (out_crc_good)
  );

  // an accepted word is in the queue at the next edge
  `CRCFAC_ASSERT_NEXT(a_push_lands, push && !full, !q_empty, "accepted word lost")

  // crc low byte follows the high byte directly
  `CRCFAC_ASSERT_NEXT(a_crc_lo_follows,
    !empty && pop && out_is_crc_byte && !out_out_last,
    !empty && out_is_crc_byte && out_out_last, "crc low byte not next")

  // crc_good only on a passed-through final byte
  `CRCFAC_ASSERT_SAME(a_good_on_last, !empty && out_crc_good,
    out_out_last && !out_is_crc_byte, "crc_good outside frame end")

endmodule

>>> rtl/crcfac_front.sv
// ----------------------------------------------------------------------------
// crcfac_front
// accepts frame bytes, folds them into the running crc and tags each word
// ----------------------------------------------------------------------------
module crcfac_front import crcfac_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [7:0]    data_byte,
  input  logic          frame_end,
  input  logic          check_mode,
  input  logic          q_full,
  output logic          full,
  output logic          q_push,
  output crcfac_entry_t q_entry
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] crc_fold;

  assign full     = q_full;
  assign q_push   = push && !q_full;
  assign crc_fold = crcfac_fold(crc_r, data_byte);

  assign q_entry.data_byte = data_byte;
  assign q_entry.last      = frame_end;
  assign q_entry.check     = check_mode;
  assign q_entry.crc       = crc_fold;

  // remainder clears at the end of every frame
  always_comb begin
    crc_nxt = crc_r;
    if (q_push) begin
      crc_nxt = frame_end ? 16'h0000 : crc_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 16'h0000;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

>>> rtl/crcfac_queue.sv
// ----------------------------------------------------------------------------
// crcfac_queue
// short fifo of tagged words between the front and the back
// ----------------------------------------------------------------------------
module crcfac_queue import crcfac_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  crcfac_entry_t push_entry,
  output logic          full,
  input  logic          pop,
  output crcfac_entry_t head,
  output logic          empty
);

  crcfac_entry_t      slot_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]       count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> rtl/crcfac_back.sv
// ----------------------------------------------------------------------------
// crcfac_back
// expands tagged words into result words and holds the output register
// ----------------------------------------------------------------------------
module crcfac_back import crcfac_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  crcfac_entry_t q_head,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          is_crc_byte,
  output logic          out_last,
  output logic          crc_good
);

  crcfac_phase_t phase_r, phase_nxt;
  logic          valid_r, valid_nxt;
  logic [7:0]    byte_r;
  logic          isc_r, last_r, good_r;
  logic [7:0]    res_byte;
  logic          res_isc, res_last, res_good;
  logic          load, take, multi;

  assign load  = !valid_r || pop;
  assign take  = load && !q_empty;
  // append mode, last byte: data then crc high then crc low
  assign multi = !q_head.check && q_head.last;
  assign q_pop = take && (!multi || phase_r == PH_LO);

  always_comb begin
    res_byte = q_head.data_byte;
    res_isc  = 1'b0;
    res_last = q_head.check && q_head.last;
    res_good = q_head.check && q_head.last && (q_head.crc == 16'h0000);
    unique case (phase_r)
      PH_DATA: begin
      end
      PH_HI: begin
        res_byte = q_head.crc[15:8];
        res_isc  = 1'b1;
        res_last = 1'b0;
        res_good = 1'b0;
      end
      PH_LO: begin
        res_byte = q_head.crc[7:0];
        res_isc  = 1'b1;
        res_last = 1'b1;
        res_good = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (take && multi) begin
      unique case (phase_r)
        PH_DATA: phase_nxt = PH_HI;
        PH_HI:   phase_nxt = PH_LO;
        PH_LO:   phase_nxt = PH_DATA;
        default: phase_nxt = PH_DATA;
      endcase
    end
    valid_nxt = load ? !q_empty : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DATA;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= res_byte;
      isc_r  <= res_isc;
      last_r <= res_last;
      good_r <= res_good;
    end
  end

  assign empty       = !valid_r;
  assign out_byte    = byte_r;
  assign is_crc_byte = isc_r;
  assign out_last    = last_r;
  assign crc_good    = good_r;

endmodule
